/* sv/flock_neighbor_steering_core_defines.svh */
// Assertion macros for the neighbor steering core.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef FLOCK_NEIGHBOR_STEERING_CORE_DEFINES_SVH
`define FLOCK_NEIGHBOR_STEERING_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define FNS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define FNS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/fns_pkg.sv */
// Shared widths, types and saturation helper for the neighbor steering core.
// No dependencies; imported by every module and interface of the block.
package fns_pkg;

  // Capacity and derived widths
  localparam int unsigned MAX_NEIGHBORS = 64;
  localparam int unsigned Q_W           = 24;
  localparam int unsigned NB_LOG        = $clog2(MAX_NEIGHBORS);
  localparam int unsigned CNT_W         = $clog2(MAX_NEIGHBORS + 1);
  localparam int unsigned SUM_W         = Q_W + NB_LOG + 1;
  localparam int unsigned DIFF_W        = Q_W + NB_LOG + 2;
  localparam int unsigned PP_W          = DIFF_W + 2;
  localparam int unsigned DIV_STEP_W    = $clog2(DIFF_W);
  localparam int unsigned OUT_CNT_W     = 7;
  localparam int unsigned RES_NUM       = 6;

  // Saturation bounds at post-processing width
  localparam logic signed [PP_W-1:0] PP_MAX = {{(PP_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
  localparam logic signed [PP_W-1:0] PP_MIN = {{(PP_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};

  // Result vector being formed
  typedef enum logic [2:0] {
    RES_SEP_X   = 3'd0,
    RES_SEP_Y   = 3'd1,
    RES_ALIGN_X = 3'd2,
    RES_ALIGN_Y = 3'd3,
    RES_COH_X   = 3'd4,
    RES_COH_Y   = 3'd5
  } res_sel_e;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_WAIT  = 4'b0100,
    S_PUSH  = 4'b1000
  } seq_state_e;

  // One input item
  typedef struct packed {
    logic signed [Q_W-1:0] own_x;
    logic signed [Q_W-1:0] own_y;
    logic signed [Q_W-1:0] nb_x;
    logic signed [Q_W-1:0] nb_y;
    logic signed [Q_W-1:0] nb_vx;
    logic signed [Q_W-1:0] nb_vy;
    logic                  has_neighbor;
    logic                  last;
  } fns_item_t;

  // Accumulator control
  typedef struct packed {
    logic take;
    logic clear;
  } acc_cmd_t;

  // Accumulator state seen by the sequencer
  typedef struct packed {
    logic signed [DIFF_W-1:0] diff_sum_x;
    logic signed [DIFF_W-1:0] diff_sum_y;
    logic signed [SUM_W-1:0]  vel_sum_x;
    logic signed [SUM_W-1:0]  vel_sum_y;
    logic signed [SUM_W-1:0]  pos_sum_x;
    logic signed [SUM_W-1:0]  pos_sum_y;
    logic [CNT_W-1:0]         count;
    logic                     overflow_seen;
    logic signed [Q_W-1:0]    own_x;
    logic signed [Q_W-1:0]    own_y;
  } acc_sums_t;

  // Divider request and response
  typedef struct packed {
    logic                     start;
    logic signed [DIFF_W-1:0] dividend;
    logic [CNT_W-1:0]         divisor;
  } div_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [DIFF_W-1:0] quotient;
  } div_rsp_t;

  // Clamp a post-processed value into Q15.8
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PP_W-1:0] v);
    logic signed [PP_W-1:0] c;
    c = v;
    if (v > PP_MAX) c = PP_MAX;
    if (v < PP_MIN) c = PP_MIN;
    return c[Q_W-1:0];
  endfunction

endpackage

/* sv/fns_ifs.sv */
// Valid/ready stream interfaces for the neighbor steering core.
// Depends on fns_pkg for field widths.
interface fns_in_if import fns_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [Q_W-1:0] own_x;
  logic signed [Q_W-1:0] own_y;
  logic signed [Q_W-1:0] nb_x;
  logic signed [Q_W-1:0] nb_y;
  logic signed [Q_W-1:0] nb_vx;
  logic signed [Q_W-1:0] nb_vy;
  logic                  has_neighbor;
  logic                  last;

  modport source (output valid, own_x, own_y, nb_x, nb_y, nb_vx, nb_vy, has_neighbor, last,
                  input ready);
  modport sink (input valid, own_x, own_y, nb_x, nb_y, nb_vx, nb_vy, has_neighbor, last,
                output ready);
endinterface

interface fns_out_if import fns_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [Q_W-1:0] sep_x;
  logic signed [Q_W-1:0] sep_y;
  logic signed [Q_W-1:0] align_x;
  logic signed [Q_W-1:0] align_y;
  logic signed [Q_W-1:0] coh_x;
  logic signed [Q_W-1:0] coh_y;
  logic [OUT_CNT_W-1:0]  neighbor_count;
  logic                  too_many;

  modport source (output valid, sep_x, sep_y, align_x, align_y, coh_x, coh_y,
                  neighbor_count, too_many, input ready);
  modport sink (input valid, sep_x, sep_y, align_x, align_y, coh_x, coh_y,
                neighbor_count, too_many, output ready);
endinterface

/* sv/flock_neighbor_steering_core.sv */
// Neighbor steering core: items without last are taken while ready stays high.
// An item with last drops ready for six divisions through one bit-serial divider (none
// for an empty set), then holds it low until the output load.
// The result waits in an output register; new items are taken while it waits.
// Reset (rst_ni low, asynchronous) clears sums, count, overflow flag and sequencer.
// Depends on fns_pkg, fns_ifs, fns_accum, fns_div and the defines header.
`include "flock_neighbor_steering_core_defines.svh"

module flock_neighbor_steering_core import fns_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  fns_in_if.sink    nb_in_i,
  fns_out_if.source res_out_o
);

  seq_state_e state_q, state_d;
  res_sel_e   idx_q, idx_d;

  fns_item_t  item;
  acc_cmd_t   acc_cmd;
  acc_sums_t  acc;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  logic                  in_xfer, out_xfer, load_out;
  logic                  empty_set;
  logic signed [Q_W-1:0] res_q [RES_NUM];
  logic signed [Q_W-1:0] pp_val;

  logic signed [PP_W-1:0] q_ext, tri_v, half_v, own_ext, coh_v;

  logic                  out_valid_q;
  logic signed [Q_W-1:0] out_res_q [RES_NUM];
  logic [OUT_CNT_W-1:0]  out_cnt_q;
  logic                  out_ovf_q;

  // Input handshake
  assign nb_in_i.ready = (state_q == S_IDLE);
  assign in_xfer       = nb_in_i.valid && nb_in_i.ready;
  assign out_xfer      = out_valid_q && res_out_o.ready;
  assign empty_set     = (acc.count == '0);

  assign item.own_x        = nb_in_i.own_x;
  assign item.own_y        = nb_in_i.own_y;
  assign item.nb_x         = nb_in_i.nb_x;
  assign item.nb_y         = nb_in_i.nb_y;
  assign item.nb_vx        = nb_in_i.nb_vx;
  assign item.nb_vy        = nb_in_i.nb_vy;
  assign item.has_neighbor = nb_in_i.has_neighbor;
  assign item.last         = nb_in_i.last;

  // Push the finished set once the output register is free
  assign load_out = (state_q == S_PUSH) && (!out_valid_q || res_out_o.ready);

  assign acc_cmd.take  = in_xfer;
  assign acc_cmd.clear = load_out;

  fns_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (acc_cmd),
    .item_i (item),
    .sums_o (acc)
  );

  // Select the sum for the current result vector
  always_comb begin
    div_req.start   = (state_q == S_START) && !empty_set;
    div_req.divisor = acc.count;
    case (idx_q)
      RES_SEP_X:   div_req.dividend = acc.diff_sum_x;
      RES_SEP_Y:   div_req.dividend = acc.diff_sum_y;
      RES_ALIGN_X: div_req.dividend = DIFF_W'(acc.vel_sum_x);
      RES_ALIGN_Y: div_req.dividend = DIFF_W'(acc.vel_sum_y);
      RES_COH_X:   div_req.dividend = DIFF_W'(acc.pos_sum_x);
      RES_COH_Y:   div_req.dividend = DIFF_W'(acc.pos_sum_y);
      default:     div_req.dividend = '0;
    endcase
  end

  fns_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Post-process the mean: times 1.5 toward zero, or minus own position; then clamp
  always_comb begin
    q_ext   = PP_W'(div_rsp.quotient);
    tri_v   = q_ext + (q_ext <<< 1);
    half_v  = (tri_v + signed'(PP_W'(tri_v[PP_W-1]))) >>> 1;
    own_ext = (idx_q == RES_COH_Y) ? PP_W'(acc.own_y) : PP_W'(acc.own_x);
    coh_v   = q_ext - own_ext;
    case (idx_q)
      RES_COH_X, RES_COH_Y: pp_val = sat_q(coh_v);
      default:              pp_val = sat_q(half_v);
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer && nb_in_i.last) begin
          state_d = S_START;
          idx_d   = RES_SEP_X;
        end
      end
      S_START: begin
        state_d = empty_set ? S_PUSH : S_WAIT;
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          if (idx_q == RES_COH_Y) begin
            state_d = S_PUSH;
          end else begin
            idx_d   = res_sel_e'(idx_q + 3'd1);
            state_d = S_START;
          end
        end
      end
      S_PUSH: begin
        if (load_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= RES_SEP_X;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the vectors of the set being formed
  always_ff @(posedge clk_i) begin
    if ((state_q == S_START) && empty_set) begin
      for (int i = 0; i < RES_NUM; i++) res_q[i] <= '0;
    end else if ((state_q == S_WAIT) && div_rsp.done) begin
      res_q[idx_q] <= pp_val;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      for (int i = 0; i < RES_NUM; i++) out_res_q[i] <= res_q[i];
      out_cnt_q <= OUT_CNT_W'(acc.count);
      out_ovf_q <= acc.overflow_seen;
    end
  end

  assign res_out_o.valid          = out_valid_q;
  assign res_out_o.sep_x          = out_res_q[RES_SEP_X];
  assign res_out_o.sep_y          = out_res_q[RES_SEP_Y];
  assign res_out_o.align_x        = out_res_q[RES_ALIGN_X];
  assign res_out_o.align_y        = out_res_q[RES_ALIGN_Y];
  assign res_out_o.coh_x          = out_res_q[RES_COH_X];
  assign res_out_o.coh_y          = out_res_q[RES_COH_Y];
  assign res_out_o.neighbor_count = out_cnt_q;
  assign res_out_o.too_many       = out_ovf_q;

  // Checks
  `FNS_ASSERT_NEXT(a_last_starts, in_xfer && nb_in_i.last, state_q == S_START, "last item did not start the sequencer")
  `FNS_ASSERT_NOW(a_count_cap, 1'b1, acc.count <= CNT_W'(MAX_NEIGHBORS), "neighbor count above capacity")
  `FNS_ASSERT_NOW(a_done_in_wait, div_rsp.done, state_q == S_WAIT, "divider finished outside the wait state")
  `FNS_ASSERT_NOW(a_busy_in_wait, div_rsp.busy, state_q == S_WAIT, "divider busy outside the wait state")
  `FNS_ASSERT_NOW(a_empty_zero, out_valid_q && (out_cnt_q == '0), (out_res_q[RES_SEP_X] == '0) && (out_res_q[RES_COH_X] == '0) && (out_res_q[RES_COH_Y] == '0), "empty set gave nonzero vectors")

endmodule

/* sv/fns_accum.sv */
// Neighbor accumulator: running sums, count, overflow flag, own position of last item.
// Depends on fns_pkg.
module fns_accum import fns_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  acc_cmd_t  cmd_i,
  input  fns_item_t item_i,
  output acc_sums_t sums_o
);

  acc_sums_t sums_q, sums_d;
  logic      room;

  assign room = (sums_q.count < CNT_W'(MAX_NEIGHBORS));

  // Add one neighbor per transfer, drop it when full
  always_comb begin
    sums_d = sums_q;
    if (cmd_i.clear) begin
      sums_d = '0;
    end else if (cmd_i.take) begin
      if (item_i.has_neighbor) begin
        if (room) begin
          sums_d.diff_sum_x = sums_q.diff_sum_x + DIFF_W'(item_i.own_x) - DIFF_W'(item_i.nb_x);
          sums_d.diff_sum_y = sums_q.diff_sum_y + DIFF_W'(item_i.own_y) - DIFF_W'(item_i.nb_y);
          sums_d.vel_sum_x  = sums_q.vel_sum_x + SUM_W'(item_i.nb_vx);
          sums_d.vel_sum_y  = sums_q.vel_sum_y + SUM_W'(item_i.nb_vy);
          sums_d.pos_sum_x  = sums_q.pos_sum_x + SUM_W'(item_i.nb_x);
          sums_d.pos_sum_y  = sums_q.pos_sum_y + SUM_W'(item_i.nb_y);
          sums_d.count      = sums_q.count + CNT_W'(1);
        end else begin
          sums_d.overflow_seen = 1'b1;
        end
      end
      if (item_i.last) begin
        sums_d.own_x = item_i.own_x;
        sums_d.own_y = item_i.own_y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q <= '0;
    end else begin
      sums_q <= sums_d;
    end
  end

  assign sums_o = sums_q;

endmodule

/* sv/fns_div.sv */
// Shared restoring divider: signed sum by unsigned count, one quotient bit per cycle.
// Quotient truncates toward zero. Depends on fns_pkg.
module fns_div import fns_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam logic [DIV_STEP_W-1:0] LAST_STEP = DIV_STEP_W'(DIFF_W - 1);

  logic                  busy_q, done_q;
  logic [DIV_STEP_W-1:0] step_q;
  logic                  neg_q;
  logic [DIFF_W-1:0]     quo_q;
  logic [CNT_W-1:0]      rem_q;
  logic [CNT_W-1:0]      dvs_q;

  logic [DIFF_W-1:0]     mag;
  logic [CNT_W:0]        rem_sh, rem_nx;
  logic                  ge;

  // Magnitude of the dividend
  assign mag = req_i.dividend[DIFF_W-1] ? (~req_i.dividend + DIFF_W'(1)) : req_i.dividend;

  // One restoring step: shift in the next dividend bit, trial subtract
  assign rem_sh = {rem_q, quo_q[DIFF_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs_q});
  assign rem_nx = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

  // Control: step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= LAST_STEP;
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - DIV_STEP_W'(1);
        end
      end
    end
  end

  // Datapath: load operands, then shift quotient bits in
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= mag;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
      neg_q <= req_i.dividend[DIFF_W-1];
    end else if (busy_q) begin
      quo_q <= {quo_q[DIFF_W-2:0], ge};
      rem_q <= rem_nx[CNT_W-1:0];
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? signed'(~quo_q + DIFF_W'(1)) : signed'(quo_q);

endmodule
